// ===== sv/rgbs_pkg.sv =====
package rgbs_pkg;

    // Default frame size in pixels.
    localparam int unsigned MAX_PIXELS_DEF = 131072;

    // Field widths.
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned IN_IDX_W   = 17;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned MEAN_W     = PIX_W + FRAC_W;
    localparam int unsigned VAR_W      = 24;
    localparam int unsigned ALPHA_W    = 16;
    localparam int unsigned THR_W      = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 56;
    localparam int unsigned RAM_W      = MEAN_W + VAR_W;

    // Number of update stages between the model read and the write-back.
    localparam int unsigned N_BACK = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR = 2'd2;

    // Configuration reset values.
    localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 16'd655;
    localparam logic [THR_W-1:0]   THRESH_RESET   = 8'd44;
    localparam logic [VAR_W-1:0]   INIT_VAR_RESET = 24'd0;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [THR_W-1:0]   thresh;
        logic [VAR_W-1:0]   init_var;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             first;
    } t_item;

    typedef struct packed {
        logic              fg;
        logic [VAR_W-1:0]  variance;
        logic [MEAN_W-1:0] mean;
        logic [MEAN_W-1:0] distance;
    } t_result;

endpackage

// ===== sv/rgbs_index_wrap.sv =====
module rgbs_index_wrap
    import rgbs_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
    localparam int unsigned IW = $clog2(MAX_PIXELS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_item               i_item,
    input  logic [IN_IDX_W-1:0] i_idx,
    output logic                o_valid,
    output t_item               o_item,
    output logic [IW-1:0]       o_idx
);

    // Reduction by multiplication with a truncated reciprocal: the quotient
    // comes out exact or one low, so one compare and subtract finishes it.
    localparam bit WRAP = (MAX_PIXELS < (1 << IN_IDX_W));
    localparam int unsigned SHIFT   = IN_IDX_W + $clog2(MAX_PIXELS);
    localparam int unsigned RECIP_W = IN_IDX_W + 2;
    localparam int unsigned PROD_W  = IN_IDX_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(MAX_PIXELS);
    localparam logic [RECIP_W-1:0]  RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [IN_IDX_W-1:0] MODV  = IN_IDX_W'(MAX_PIXELS);

    logic                  r_a_valid;
    t_item                 r_a_item;
    logic [IN_IDX_W-1:0]   r_a_idx;
    logic [PROD_W-1:0]     r_a_prod;
    logic                  r_b_valid;
    t_item                 r_b_item;
    logic [IN_IDX_W-1:0]   r_b_idx;
    logic [2*IN_IDX_W-1:0] r_b_mul;
    logic                  r_x_valid;
    t_item                 r_x_item;
    logic [IW-1:0]         r_x_idx;

    logic [PROD_W-1:0]     n_a_prod;
    logic [IN_IDX_W-1:0]   quot;
    logic [2*IN_IDX_W-1:0] n_b_mul;
    logic [IN_IDX_W-1:0]   diff;
    logic [IN_IDX_W-1:0]   reduced;
    logic [IW-1:0]         n_x_idx;

    // Quotient estimate and its product with the frame size.
    assign n_a_prod = PROD_W'(i_idx) * PROD_W'(RECIP);
    assign quot     = IN_IDX_W'(r_a_prod >> SHIFT);
    assign n_b_mul  = (2*IN_IDX_W)'(quot) * (2*IN_IDX_W)'(MODV);

    // Remainder with a single correction step.
    assign diff    = r_b_idx - r_b_mul[IN_IDX_W-1:0];
    assign reduced = (diff >= MODV) ? (diff - MODV) : diff;

    generate
        if (WRAP) begin : g_wrap
            assign n_x_idx = reduced[IW-1:0];
        end else if (IW == IN_IDX_W) begin : g_same
            assign n_x_idx = r_b_idx;
        end else begin : g_wide
            assign n_x_idx = {{(IW-IN_IDX_W){1'b0}}, r_b_idx};
        end
    endgenerate

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_x_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_x_valid <= r_b_valid;
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_a_idx  <= i_idx;
            r_a_prod <= n_a_prod;
            r_b_item <= r_a_item;
            r_b_idx  <= r_a_idx;
            r_b_mul  <= n_b_mul;
            r_x_item <= r_b_item;
            r_x_idx  <= n_x_idx;
        end
    end

    assign o_valid = r_x_valid;
    assign o_item  = r_x_item;
    assign o_idx   = r_x_idx;

endmodule

// ===== sv/rgbs_model_ram.sv =====
module rgbs_model_ram
    import rgbs_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
    localparam int unsigned IW = $clog2(MAX_PIXELS)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_addr,
    input  logic [RAM_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [IW-1:0]    i_rd_addr,
    output logic [RAM_W-1:0] o_rd_data
);

    logic [RAM_W-1:0] r_mem [MAX_PIXELS];
    logic [RAM_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; holds its data while the reader stalls.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/rgbs_update_pipe.sv =====
module rgbs_update_pipe
    import rgbs_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
    localparam int unsigned IW = $clog2(MAX_PIXELS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  t_item                      i_item,
    input  logic [IW-1:0]              i_idx,
    input  logic [MEAN_W-1:0]          i_mean_old,
    input  logic [VAR_W-1:0]           i_var_old,
    input  t_cfg                       i_cfg,
    output logic                       o_valid,
    output logic [IW-1:0]              o_idx,
    output t_result                    o_result,
    output logic [N_BACK-1:0]          o_tag_valid,
    output logic [N_BACK-1:0][IW-1:0]  o_tag_idx
);

    localparam int unsigned PK_W   = ALPHA_W + 1 + MEAN_W;
    localparam int unsigned PA_W   = ALPHA_W + MEAN_W;
    localparam int unsigned MSUM_W = PK_W + 1;
    localparam int unsigned DD_W   = 2 * MEAN_W;
    localparam int unsigned VK_W   = ALPHA_W + 1 + VAR_W;
    localparam int unsigned VA_W   = ALPHA_W + VAR_W;
    localparam int unsigned VSUM_W = VK_W + 1;
    localparam logic [ALPHA_W:0]    KEEP_BASE = {1'b1, {ALPHA_W{1'b0}}};
    localparam logic [MSUM_W-1:0]   M_HALF = MSUM_W'(1) << (ALPHA_W - 1);
    localparam logic [VSUM_W-1:0]   V_HALF = VSUM_W'(1) << (ALPHA_W - 1);
    localparam logic [DD_W:0]       D_HALF = (DD_W + 1)'(1) << (FRAC_W - 1);

    // Stage valid bits, indexes and items, one entry per stage.
    logic [N_BACK-1:0]         r_valid;
    logic [N_BACK-1:0][IW-1:0] r_idx;
    t_item                     r_item [N_BACK];

    // Stage payload.
    logic [PK_W-1:0]   r2_pk;
    logic [PA_W-1:0]   r2_pa;
    logic [VAR_W-1:0]  r2_vold;
    logic [MEAN_W-1:0] r3_mean;
    logic [MEAN_W-1:0] r3_dist;
    logic [VAR_W-1:0]  r3_vold;
    logic [DD_W-1:0]   r4_dd;
    logic [MEAN_W-1:0] r4_mean;
    logic [MEAN_W-1:0] r4_dist;
    logic [VAR_W-1:0]  r4_vold;
    logic [VAR_W-1:0]  r5_d2;
    logic [MEAN_W-1:0] r5_mean;
    logic [MEAN_W-1:0] r5_dist;
    logic [VAR_W-1:0]  r5_vold;
    logic [VK_W-1:0]   r6_pvk;
    logic [VA_W-1:0]   r6_pva;
    logic [MEAN_W-1:0] r6_mean;
    logic [MEAN_W-1:0] r6_dist;

    logic [ALPHA_W:0]    keep;
    logic [PK_W-1:0]     n2_pk;
    logic [PA_W-1:0]     n2_pa;
    logic [MEAN_W-1:0]   big_p1;
    logic [MEAN_W-1:0]   big_p2;
    logic [MSUM_W-1:0]   mean_sum;
    logic [MEAN_W-1:0]   mean_sat;
    logic [MEAN_W-1:0]   n3_mean;
    logic [MEAN_W-1:0]   n3_dist;
    logic [DD_W-1:0]     n4_dd;
    logic [DD_W:0]       d2_sum;
    logic [VAR_W-1:0]    n5_d2;
    logic [VK_W-1:0]     n6_pvk;
    logic [VA_W-1:0]     n6_pva;
    logic [VSUM_W-1:0]   var_sum;
    logic [VAR_W-1:0]    var_new;

    assign keep = KEEP_BASE - {1'b0, i_cfg.alpha};

    // Stage 1: mean blend products from the stored mean.
    assign big_p1 = {r_item[0].pixel, {FRAC_W{1'b0}}};
    assign n2_pk  = PK_W'(keep) * PK_W'(i_mean_old);
    assign n2_pa  = PA_W'(i_cfg.alpha) * PA_W'(big_p1);

    // Stage 2: round and saturate the mean (first frame takes the pixel), then take the distance.
    assign big_p2   = {r_item[1].pixel, {FRAC_W{1'b0}}};
    assign mean_sum = {1'b0, r2_pk} + MSUM_W'(r2_pa) + M_HALF;
    assign mean_sat = (|mean_sum[MSUM_W-1:ALPHA_W+MEAN_W]) ? {MEAN_W{1'b1}}
                                                           : mean_sum[ALPHA_W+MEAN_W-1:ALPHA_W];
    assign n3_mean  = r_item[1].first ? big_p2 : mean_sat;
    assign n3_dist  = (big_p2 >= n3_mean) ? (big_p2 - n3_mean) : (n3_mean - big_p2);

    // Stage 3: square of the distance.
    assign n4_dd = DD_W'(r3_dist) * DD_W'(r3_dist);

    // Stage 4: squared distance back to Q16.8 with rounding and saturation.
    assign d2_sum = {1'b0, r4_dd} + D_HALF;
    assign n5_d2  = (|d2_sum[DD_W:FRAC_W+VAR_W]) ? {VAR_W{1'b1}}
                                                 : d2_sum[FRAC_W+VAR_W-1:FRAC_W];

    // Stage 5: variance blend products.
    assign n6_pvk = VK_W'(keep) * VK_W'(r5_vold);
    assign n6_pva = VA_W'(i_cfg.alpha) * VA_W'(r5_d2);

    // Stage 6: round and saturate the variance; first frame loads the seed.
    assign var_sum = {1'b0, r6_pvk} + VSUM_W'(r6_pva) + V_HALF;
    assign var_new = r_item[N_BACK-1].first ? i_cfg.init_var
                   : ((|var_sum[VSUM_W-1:ALPHA_W+VAR_W]) ? {VAR_W{1'b1}}
                                                         : var_sum[ALPHA_W+VAR_W-1:ALPHA_W]);

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[N_BACK-2:0], i_valid};
        end
    end

    // Index and item shift line.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx[0]  <= i_idx;
            r_item[0] <= i_item;
            for (int k = 1; k < N_BACK; k++) begin
                r_idx[k]  <= r_idx[k-1];
                r_item[k] <= r_item[k-1];
            end
        end
    end

    // Arithmetic stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pk   <= n2_pk;
            r2_pa   <= n2_pa;
            r2_vold <= i_var_old;
            r3_mean <= n3_mean;
            r3_dist <= n3_dist;
            r3_vold <= r2_vold;
            r4_dd   <= n4_dd;
            r4_mean <= r3_mean;
            r4_dist <= r3_dist;
            r4_vold <= r3_vold;
            r5_d2   <= n5_d2;
            r5_mean <= r4_mean;
            r5_dist <= r4_dist;
            r5_vold <= r4_vold;
            r6_pvk  <= n6_pvk;
            r6_pva  <= n6_pva;
            r6_mean <= r5_mean;
            r6_dist <= r5_dist;
        end
    end

    assign o_valid           = r_valid[N_BACK-1];
    assign o_idx             = r_idx[N_BACK-1];
    assign o_result.fg       = (r6_dist > {i_cfg.thresh, {FRAC_W{1'b0}}});
    assign o_result.variance = var_new;
    assign o_result.mean     = r6_mean;
    assign o_result.distance = r6_dist;
    assign o_tag_valid       = r_valid;
    assign o_tag_idx         = r_idx;

endmodule

// ===== sv/rgbs_out_buf.sv =====
module rgbs_out_buf
    import rgbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_full
);

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Result slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);

endmodule

// ===== sv/running_gaussian_background_subtract_unit.sv =====
// A pixel's result passes the index wrap stages, the update stages and the output buffer.
// Throughput: one pixel per cycle while the output buffer has room, set by the model
// memory's single read and write port; an updating (not first-frame) pixel whose
// wrapped index matches one of the six items still in the update stages waits at
// the read stage until that item is written back.
// Reset: synchronous, active low; clears valid bits, the output buffer and the
// configuration registers. The model memory is not cleared.
module running_gaussian_background_subtract_unit
    import rgbs_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // pixel_value[7:0], pixel_index[24:8], zero pad
    input  logic [0:0]            i_s_tuser,   // first_frame[0]
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // distance[15:0], mean_out[31:16], variance_out[55:32]
    output logic [0:0]            o_m_tuser,   // foreground[0]
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned IW = $clog2(MAX_PIXELS);

    t_cfg                      r_cfg;
    t_item                     in_item;
    logic                      x_valid;
    t_item                     x_item;
    logic [IW-1:0]             x_idx;
    logic                      hazard;
    logic                      en_back;
    logic                      en_front;
    logic [RAM_W-1:0]          ram_rd;
    logic                      wb_valid;
    logic [IW-1:0]             wb_idx;
    t_result                   wb_result;
    logic                      wb_push;
    logic [N_BACK-1:0]         tag_valid;
    logic [N_BACK-1:0][IW-1:0] tag_idx;
    logic                      out_full;
    t_result                   out_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha    <= ALPHA_RESET;
            r_cfg.thresh   <= THRESH_RESET;
            r_cfg.init_var <= INIT_VAR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA:    r_cfg.alpha    <= i_cfg_data[ALPHA_W-1:0];
                CFG_THRESH:   r_cfg.thresh   <= i_cfg_data[THR_W-1:0];
                CFG_INIT_VAR: r_cfg.init_var <= i_cfg_data[VAR_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // The back end moves whenever the output buffer can take its result.
    assign en_back = !out_full || i_m_tready;

    // A pixel that updates the model must not read an entry that an older
    // pixel in the update stages has yet to write back.
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < N_BACK; k++) begin
            if (tag_valid[k] && (tag_idx[k] == x_idx)) begin
                hazard = 1'b1;
            end
        end
        hazard = hazard && x_valid && !x_item.first;
    end

    assign en_front   = en_back && !hazard;
    assign o_s_tready = en_front;

    assign in_item.pixel = i_s_tdata[PIX_W-1:0];
    assign in_item.first = i_s_tuser[0];

    // Index wrap stages.
    rgbs_index_wrap #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_front),
        .i_valid (i_s_tvalid),
        .i_item  (in_item),
        .i_idx   (i_s_tdata[PIX_W+IN_IDX_W-1:PIX_W]),
        .o_valid (x_valid),
        .o_item  (x_item),
        .o_idx   (x_idx)
    );

    // Per-pixel mean and variance memory.
    assign wb_push = wb_valid && en_back;

    rgbs_model_ram #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wb_push),
        .i_wr_addr (wb_idx),
        .i_wr_data ({wb_result.variance, wb_result.mean}),
        .i_rd_en   (en_front),
        .i_rd_addr (x_idx),
        .o_rd_data (ram_rd)
    );

    // Update stages.
    rgbs_update_pipe #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en_back),
        .i_valid     (x_valid && !hazard),
        .i_item      (x_item),
        .i_idx       (x_idx),
        .i_mean_old  (ram_rd[MEAN_W-1:0]),
        .i_var_old   (ram_rd[RAM_W-1:MEAN_W]),
        .i_cfg       (r_cfg),
        .o_valid     (wb_valid),
        .o_idx       (wb_idx),
        .o_result    (wb_result),
        .o_tag_valid (tag_valid),
        .o_tag_idx   (tag_idx)
    );

    // Output buffer.
    rgbs_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wb_push),
        .i_data  (wb_result),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (out_data),
        .o_full  (out_full)
    );

    assign o_m_tdata = {out_data.variance, out_data.mean, out_data.distance};
    assign o_m_tuser = out_data.fg;

    // A stalled back end keeps its stage occupancy.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en_back |=> $stable(tag_valid))
        else $error("update stages moved during a stall");

    // A pixel held at the read stage leaves a bubble behind it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_back && hazard) |=> !tag_valid[0])
        else $error("held pixel entered the update stages");

    // An updating read never collides with the write-back of the same entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_front && x_valid && !x_item.first && wb_push) |-> (wb_idx != x_idx))
        else $error("model read collided with write-back");

endmodule
